// ----- src/ecms_pkg.sv -----
// ecms_pkg: shared types and mode codes for the ev charger mode sequencer
// used by all modules under src, depends on nothing
package ecms_pkg;

    localparam logic [3:0] MODE_STARTUP      = 4'd0;
    localparam logic [3:0] MODE_CHECK_SWITCH = 4'd1;
    localparam logic [3:0] MODE_UNLATCHED120 = 4'd2;
    localparam logic [3:0] MODE_CHARGING120  = 4'd3;
    localparam logic [3:0] MODE_B2CHECK      = 4'd4;
    localparam logic [3:0] MODE_C2CHECK      = 4'd5;
    localparam logic [3:0] MODE_UNLATCHED240 = 4'd6;
    localparam logic [3:0] MODE_CHARGING240  = 4'd7;
    localparam logic [3:0] MODE_ERROR        = 4'd8;

    localparam logic [15:0] DWELL_RESET = 16'd1000;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        low_volt_ok;
        logic        sel_120;
        logic        sel_240;
        logic        latch_high;
        logic        evse_b2_ready;
        logic        evse_c2_ready;
        logic        high_volt_ok;
        logic        clear_fault;
    } tick_t;

    typedef struct packed {
        logic [3:0] mode;
        logic       shutdown_enable;
        logic       charge_enable;
        logic       restart_timer_pulse;
    } result_t;

endpackage

// ----- src/ecms_in_reg.sv -----
// ecms_in_reg: input register stage holding one tick word
// depends on ecms_pkg
module ecms_in_reg
    import ecms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  tick_t tick_in,
    input  logic  advance,
    output logic  s1_valid,
    output tick_t s1_tick
);

    logic  valid_reg;
    logic  valid_next;
    tick_t tick_reg;
    logic  load;

    assign in_stall = valid_reg & ~advance;
    assign load     = in_valid & ~in_stall;

    always_comb
    begin
        if (valid_reg && !advance)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tick_reg <= tick_in;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_tick  = tick_reg;

endmodule

// ----- src/ecms_fsm.sv -----
// ecms_fsm: mode state, dwell timer, line levels and the dwell register
// depends on ecms_pkg
module ecms_fsm
    import ecms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_dwell_ms,
    input  logic        step_en,
    input  tick_t       tick,
    output result_t     result_next
);

    logic [3:0]  mode_reg;
    logic [31:0] entered_reg;
    logic        shutdown_reg;
    logic        charge_reg;
    logic [15:0] dwell_reg;

    logic [3:0]  mode_next;
    logic        shutdown_next;
    logic        charge_next;
    logic        pulse_next;
    logic        go;
    logic [3:0]  target;
    logic [31:0] elapsed;
    logic        waited;

    assign elapsed = tick.now_ms - entered_reg;
    assign waited  = elapsed >= {16'd0, dwell_reg};

    always_comb
    begin
        go     = 1'b0;
        target = mode_reg;
        unique case (mode_reg)
            MODE_STARTUP:
            begin
                if (waited)
                begin
                    go     = 1'b1;
                    target = tick.low_volt_ok ? MODE_CHECK_SWITCH : MODE_ERROR;
                end
            end
            MODE_CHECK_SWITCH:
            begin
                if (waited)
                begin
                    priority if (!tick.low_volt_ok)
                    begin
                        go     = 1'b1;
                        target = MODE_ERROR;
                    end
                    else if (tick.sel_120)
                    begin
                        go     = 1'b1;
                        target = MODE_UNLATCHED120;
                    end
                    else if (tick.sel_240)
                    begin
                        go     = 1'b1;
                        target = MODE_B2CHECK;
                    end
                    else
                    begin
                        go = 1'b0;
                    end
                end
            end
            MODE_UNLATCHED120:
            begin
                priority if (!tick.low_volt_ok || !tick.sel_120)
                begin
                    go     = 1'b1;
                    target = MODE_ERROR;
                end
                else if (tick.latch_high)
                begin
                    go     = 1'b1;
                    target = MODE_CHARGING120;
                end
                else
                begin
                    go = 1'b0;
                end
            end
            MODE_CHARGING120:
            begin
                if (!tick.low_volt_ok || !tick.sel_120)
                begin
                    go     = 1'b1;
                    target = MODE_ERROR;
                end
            end
            MODE_B2CHECK:
            begin
                if (waited && tick.evse_b2_ready)
                begin
                    go     = 1'b1;
                    target = MODE_C2CHECK;
                end
            end
            MODE_C2CHECK:
            begin
                if (waited)
                begin
                    priority if (!tick.high_volt_ok)
                    begin
                        go     = 1'b1;
                        target = MODE_ERROR;
                    end
                    else if (tick.evse_c2_ready)
                    begin
                        go     = 1'b1;
                        target = MODE_UNLATCHED240;
                    end
                    else
                    begin
                        go = 1'b0;
                    end
                end
            end
            MODE_UNLATCHED240:
            begin
                if (waited)
                begin
                    priority if (!tick.evse_c2_ready || !tick.high_volt_ok)
                    begin
                        go     = 1'b1;
                        target = MODE_ERROR;
                    end
                    else if (tick.latch_high)
                    begin
                        go     = 1'b1;
                        target = MODE_CHARGING240;
                    end
                    else
                    begin
                        go = 1'b0;
                    end
                end
            end
            MODE_CHARGING240:
            begin
                if (waited && (!tick.evse_c2_ready || !tick.high_volt_ok))
                begin
                    go     = 1'b1;
                    target = MODE_ERROR;
                end
            end
            MODE_ERROR:
            begin
                if (waited && tick.clear_fault)
                begin
                    go     = 1'b1;
                    target = MODE_STARTUP;
                end
            end
            default:
            begin
                go     = 1'b0;
                target = mode_reg;
            end
        endcase
    end

    // exit action first, then entry action
    always_comb
    begin
        mode_next     = mode_reg;
        shutdown_next = shutdown_reg;
        charge_next   = charge_reg;
        pulse_next    = 1'b0;
        if (go)
        begin
            mode_next = target;
            if (mode_reg == MODE_B2CHECK)
            begin
                charge_next = 1'b1;
            end
            if (target == MODE_UNLATCHED120 || target == MODE_UNLATCHED240)
            begin
                shutdown_next = 1'b1;
            end
            if (target == MODE_CHARGING240)
            begin
                pulse_next = 1'b1;
            end
            if (target == MODE_ERROR)
            begin
                shutdown_next = 1'b0;
                charge_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_STARTUP;
            entered_reg  <= 32'd0;
            shutdown_reg <= 1'b0;
            charge_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg     <= mode_next;
            shutdown_reg <= shutdown_next;
            charge_reg   <= charge_next;
            if (go)
            begin
                entered_reg <= tick.now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg <= DWELL_RESET;
        end
        else if (cfg_we)
        begin
            dwell_reg <= cfg_dwell_ms;
        end
    end

    assign result_next.mode                = mode_next;
    assign result_next.shutdown_enable     = shutdown_next;
    assign result_next.charge_enable       = charge_next;
    assign result_next.restart_timer_pulse = pulse_next;

endmodule

// ----- src/ecms_out_reg.sv -----
// ecms_out_reg: result register feeding the output channel
// depends on ecms_pkg
module ecms_out_reg
    import ecms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  logic    s1_valid,
    input  result_t result_in,
    output logic    out_valid,
    output result_t result_out
);

    logic    valid_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// ----- src/ev_charger_mode_sequencer.sv -----
// ev_charger_mode_sequencer: top level of the charger mode sequencer
// depends on ecms_pkg, ecms_in_reg, ecms_fsm, ecms_out_reg
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | now_ms and eight condition flags
//  out     | out_valid / out_stall| mode, shutdown_enable, charge_enable,
//          |                      | restart_timer_pulse
//  cfg     | cfg_valid / cfg_ready| cfg_dwell_ms
//
// one word per cycle sustained while out_stall is low; a taken word passes the input register,
// then the transition logic, and its result is valid once the result register has loaded it
// the transition logic between the input register and the result register is combinational
// reset: startup mode, zero levels, dwell 1000 ms, both stages empty
// out_stall holds a valid result register and, once the input register is full, raises in_stall
// cfg_ready is always high
module ev_charger_mode_sequencer
    import ecms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] now_ms,
    input  logic        low_volt_ok,
    input  logic        sel_120,
    input  logic        sel_240,
    input  logic        latch_high,
    input  logic        evse_b2_ready,
    input  logic        evse_c2_ready,
    input  logic        high_volt_ok,
    input  logic        clear_fault,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  mode,
    output logic        shutdown_enable,
    output logic        charge_enable,
    output logic        restart_timer_pulse,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_dwell_ms
);

    tick_t   tick_in;
    tick_t   s1_tick;
    logic    s1_valid;
    logic    advance;
    result_t result_next;
    result_t result_out;

    assign tick_in.now_ms        = now_ms;
    assign tick_in.low_volt_ok   = low_volt_ok;
    assign tick_in.sel_120       = sel_120;
    assign tick_in.sel_240       = sel_240;
    assign tick_in.latch_high    = latch_high;
    assign tick_in.evse_b2_ready = evse_b2_ready;
    assign tick_in.evse_c2_ready = evse_c2_ready;
    assign tick_in.high_volt_ok  = high_volt_ok;
    assign tick_in.clear_fault   = clear_fault;

    assign advance   = ~out_valid | ~out_stall;
    assign cfg_ready = 1'b1;

    ecms_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .tick_in  (tick_in),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_tick  (s1_tick)
    );

    ecms_fsm u_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_dwell_ms (cfg_dwell_ms),
        .step_en      (advance & s1_valid),
        .tick         (s1_tick),
        .result_next  (result_next)
    );

    ecms_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .s1_valid   (s1_valid),
        .result_in  (result_next),
        .out_valid  (out_valid),
        .result_out (result_out)
    );

    assign mode                = result_out.mode;
    assign shutdown_enable     = result_out.shutdown_enable;
    assign charge_enable       = result_out.charge_enable;
    assign restart_timer_pulse = result_out.restart_timer_pulse;

`ifndef NO_ASSERTIONS
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mode <= MODE_ERROR))
        else $error("mode code out of range");

    a_pulse_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && restart_timer_pulse) |-> (mode == MODE_CHARGING240))
        else $error("restart pulse outside 240 V charging");

    a_error_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode == MODE_ERROR) |-> (!shutdown_enable && !charge_enable))
        else $error("line levels held in error mode");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result register free");
`endif

endmodule
